@@ rtl/core/erma_pkg.sv @@
// Shared types and constants for the event rate moving average block.
`timescale 1ns / 1ps
package erma_pkg;

  // Fixed field widths of the request and result channels.
  localparam int CHAN_W = 4;
  localparam int TS_W = 48;
  localparam int RATE_W = 10;

  // Milliseconds in one second, the numerator of the rate division.
  localparam int MS_PER_SEC = 1000;

  // Queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW = 2;

  // One request that the front hands to the back.
  typedef struct packed {
    logic [CHAN_W-1:0] channel;
    logic [TS_W-1:0]   timestamp_ms;
  } erma_item_t;

  // Status that the shared divider reports to the back sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } erma_div_status_t;

endpackage

@@ rtl/core/erma_front.sv @@
// Input stage: accepts requests, drops the ones that cause no work, holds one for the queue.
`timescale 1ns / 1ps
module erma_front #(
  parameter int NUM_CHANNELS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [55:0]           s_tdata,
  input  logic [0:0]            s_tuser,
  output logic                  push_valid,
  input  logic                  push_ready,
  output erma_pkg::erma_item_t  push_item
);
  import erma_pkg::*;

  logic       hold_valid;
  logic       hold_valid_next;
  erma_item_t hold_item;
  logic       accept;
  logic       keep;
  logic [CHAN_W-1:0] in_channel;

  assign in_channel = s_tdata[CHAN_W-1:0];
  assign s_tready   = !hold_valid || push_ready;
  assign accept     = s_tvalid && s_tready;
  // Only relative motion on an existing channel reaches the back.
  assign keep       = accept && s_tuser[0] && (32'(in_channel) < NUM_CHANNELS);

  always_comb begin
    if (keep) begin
      hold_valid_next = 1'b1;
    end else if (push_ready) begin
      hold_valid_next = 1'b0;
    end else begin
      hold_valid_next = hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else begin
      hold_valid <= hold_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (keep) begin
      hold_item.channel      <= in_channel;
      hold_item.timestamp_ms <= s_tdata[CHAN_W+TS_W-1:CHAN_W];
    end
  end

  assign push_valid = hold_valid;
  assign push_item  = hold_item;

endmodule

@@ rtl/core/erma_queue.sv @@
// Small queue that decouples the input stage from the rate sequencer.
`timescale 1ns / 1ps
module erma_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push_valid,
  output logic                  push_ready,
  input  erma_pkg::erma_item_t  push_item,
  output logic                  pop_valid,
  input  logic                  pop,
  output erma_pkg::erma_item_t  pop_item
);
  import erma_pkg::*;

  erma_item_t          entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   fill;
  logic                do_push;
  logic                do_pop;

  assign push_ready = (fill != (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_item   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

@@ rtl/core/erma_div.sv @@
// Restoring divider, one quotient bit per cycle, shared by both divisions.
`timescale 1ns / 1ps
module erma_div #(
  parameter int N_W = 16,
  parameter int D_W = 10
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [N_W-1:0]              dividend,
  input  logic [D_W-1:0]              divisor,
  output logic [N_W-1:0]              quotient,
  output erma_pkg::erma_div_status_t  status
);
  import erma_pkg::*;

  localparam int CNT_W = $clog2(N_W + 1);

  logic [N_W-1:0]   quo;
  logic [D_W-1:0]   rem;
  logic [D_W-1:0]   dvs;
  logic [CNT_W-1:0] steps;
  logic             busy;
  logic             done;
  logic [D_W:0]     rem_sh;
  logic             fits;
  logic [D_W:0]     diff;

  assign rem_sh = {rem, quo[N_W-1]};
  assign fits   = (rem_sh >= {1'b0, dvs});
  assign diff   = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy  <= 1'b1;
        steps <= CNT_W'(N_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[N_W-2:0], fits};
      rem <= fits ? diff[D_W-1:0] : rem_sh[D_W-1:0];
    end
  end

  assign quotient    = quo;
  assign status.busy = busy;
  assign status.done = done;

endmodule

@@ rtl/core/erma_back.sv @@
// Rate sequencer: channel state, rate rings, both divisions and the result register.
`timescale 1ns / 1ps
module erma_back #(
  parameter int NUM_CHANNELS = 16,
  parameter int RING_DEPTH   = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          pop_valid,
  output logic                          pop,
  input  erma_pkg::erma_item_t          pop_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [erma_pkg::CHAN_W-1:0]   out_channel,
  output logic [erma_pkg::RATE_W-1:0]   latest_rate,
  output logic [erma_pkg::RATE_W-1:0]   average_rate
);
  import erma_pkg::*;

  localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int SLOT_W = $clog2(RING_DEPTH);
  localparam int CNT_W  = $clog2(RING_DEPTH + 1);
  localparam int SUM_W  = $clog2(MS_PER_SEC * RING_DEPTH + 1);
  localparam int ADDR_W = $clog2(NUM_CHANNELS * RING_DEPTH);
  localparam int N_W    = (SUM_W > RATE_W) ? SUM_W : RATE_W;
  localparam int D_W    = (CNT_W > RATE_W) ? CNT_W : RATE_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_RATE  = 3'd3;
  localparam logic [2:0] S_SUM   = 3'd4;
  localparam logic [2:0] S_AVG   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  typedef struct packed {
    logic [TS_W-1:0]   prev_time;
    logic [SUM_W-1:0]  ring_sum;
    logic [SLOT_W-1:0] write_slot;
    logic [CNT_W-1:0]  sample_count;
  } chan_state_t;

  // Per-channel state and the rate rings, both with a registered read port.
  chan_state_t       state_mem [NUM_CHANNELS];
  logic [RATE_W-1:0] ring_mem  [NUM_CHANNELS * RING_DEPTH];

  logic [NUM_CHANNELS-1:0] chan_valid;
  logic [2:0]              state;
  logic [2:0]              state_next;

  logic [CHAN_W-1:0] cur_chan;
  logic [CH_W-1:0]   cur_idx;
  logic [TS_W-1:0]   cur_ts;
  logic [TS_W-1:0]   prev_time;
  logic [SUM_W-1:0]  ring_sum;
  logic [SLOT_W-1:0] write_slot;
  logic [CNT_W-1:0]  sample_count;
  logic [RATE_W-1:0] rate;
  logic [RATE_W-1:0] avg_rate;

  chan_state_t       state_rd;
  logic              state_hit;
  logic              state_we;
  chan_state_t       state_wr;
  logic [CH_W-1:0]   pop_idx;

  logic [RATE_W-1:0] ring_rd;
  logic              ring_re;
  logic              ring_we;
  logic [ADDR_W-1:0] ring_addr;
  logic [SLOT_W-1:0] slot_adv;

  logic [TS_W-1:0]   delta;
  logic              interval_ok;
  logic [RATE_W-1:0] old_rate;
  logic [SUM_W-1:0]  sum_new;
  logic [CNT_W-1:0]  count_new;

  logic              div_start;
  logic [N_W-1:0]    div_dividend;
  logic [D_W-1:0]    div_divisor;
  logic [N_W-1:0]    div_quotient;
  erma_div_status_t  div_status;

  logic              out_load;

  assign pop_idx  = CH_W'(pop_item.channel);
  assign cur_idx  = CH_W'(cur_chan);
  assign slot_adv = (write_slot == SLOT_W'(RING_DEPTH - 1)) ? '0 : write_slot + 1'b1;
  assign ring_addr = ADDR_W'(cur_idx) * ADDR_W'(RING_DEPTH) + ADDR_W'(slot_adv);

  // A time step backwards or a zero step fails the first test, a long gap the second.
  assign delta       = cur_ts - prev_time;
  assign interval_ok = (cur_ts > prev_time) && (delta <= TS_W'(MS_PER_SEC));

  // Until the ring has wrapped once, the slot being replaced was never written.
  assign old_rate  = (sample_count == CNT_W'(RING_DEPTH)) ? ring_rd : '0;
  assign sum_new   = ring_sum - SUM_W'(old_rate) + SUM_W'(rate);
  assign count_new = (sample_count == CNT_W'(RING_DEPTH)) ? sample_count
                                                          : sample_count + 1'b1;

  assign pop      = (state == S_IDLE) && pop_valid;
  assign ring_re  = (state == S_CHECK) && interval_ok;
  assign ring_we  = (state == S_SUM);
  assign out_load = (state == S_OUT) && (!out_valid || out_ready);

  always_comb begin
    state_we  = 1'b0;
    div_start = 1'b0;
    div_dividend = N_W'(MS_PER_SEC);
    div_divisor  = D_W'(delta[RATE_W-1:0]);
    state_wr.prev_time    = cur_ts;
    state_wr.ring_sum     = ring_sum;
    state_wr.write_slot   = write_slot;
    state_wr.sample_count = sample_count;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (pop_valid) begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (interval_ok) begin
          div_start  = 1'b1;
          state_next = S_RATE;
        end else begin
          state_we   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_RATE: begin
        if (div_status.done) begin
          state_next = S_SUM;
        end
      end
      S_SUM: begin
        div_start    = 1'b1;
        div_dividend = N_W'(sum_new);
        div_divisor  = D_W'(count_new);
        state_next   = S_AVG;
      end
      S_AVG: begin
        if (div_status.done) begin
          state_we   = 1'b1;
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      chan_valid <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state_we) begin
        chan_valid[cur_idx] <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers of the item in flight.
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_chan  <= pop_item.channel;
      cur_ts    <= pop_item.timestamp_ms;
      state_hit <= chan_valid[pop_idx];
    end
    if (state == S_LOAD) begin
      prev_time    <= state_hit ? state_rd.prev_time : '0;
      ring_sum     <= state_hit ? state_rd.ring_sum : '0;
      write_slot   <= state_hit ? state_rd.write_slot : '0;
      sample_count <= state_hit ? state_rd.sample_count : '0;
    end
    if ((state == S_RATE) && div_status.done) begin
      rate <= div_quotient[RATE_W-1:0];
    end
    // The slot advances only once the ring entry has been written.
    if (state == S_SUM) begin
      ring_sum     <= sum_new;
      sample_count <= count_new;
      write_slot   <= slot_adv;
    end
    if ((state == S_AVG) && div_status.done) begin
      avg_rate <= div_quotient[RATE_W-1:0];
    end
    if (out_load) begin
      out_channel  <= cur_chan;
      latest_rate  <= rate;
      average_rate <= avg_rate;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      state_rd <= state_mem[pop_idx];
    end
    if (state_we) begin
      state_mem[cur_idx] <= state_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (ring_re) begin
      ring_rd <= ring_mem[ring_addr];
    end
    if (ring_we) begin
      ring_mem[ring_addr] <= rate;
    end
  end

  erma_div #(
    .N_W (N_W),
    .D_W (D_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quotient),
    .status   (div_status)
  );

  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_status.busy)
    else $error("divider started while busy");

  a_rate_range: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (latest_rate != '0) && (latest_rate <= RATE_W'(MS_PER_SEC)))
    else $error("latest rate out of range");

  a_avg_range: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (average_rate <= RATE_W'(MS_PER_SEC)))
    else $error("average rate out of range");

  a_count_sat: assert property (@(posedge clk) disable iff (rst)
    state_we |-> (state_wr.sample_count <= CNT_W'(RING_DEPTH)))
    else $error("sample count above ring depth");

  a_sum_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_SUM) |-> ($past(state) == S_RATE))
    else $error("ring update without a fresh rate");

endmodule

@@ rtl/core/event_rate_moving_average.sv @@
// Top level of the per-channel event rate meter with moving average.
//
//   Channel | Direction | Signals                              | Request contents
//   --------+-----------+--------------------------------------+-------------------------------
//   s       | in        | s_tvalid, s_tready, s_tdata, s_tuser | channel, timestamp, relative
//   m       | out       | m_tvalid, m_tready, m_tdata          | channel, latest and average
//
// A relative request on an existing channel with a valid interval is worked in the back by
// the one shared bit-serial divider (N_W = 16 with a 64-slot ring), which first forms
// 1000 / interval and then sum / count; the result may then wait for the result register.
// A request that is dropped (not relative, or channel out of range) is taken at the input
// and goes no further. Reset is synchronous and active high; it clears the channel valid
// bits, so every channel restarts from zero, and the ring needs no clearing pass
// because its fill count marks which slots hold data. The input stage and a four-deep
// queue keep accepting requests while the back works or the result register waits,
// until they fill.
`timescale 1ns / 1ps
module event_rate_moving_average #(
  parameter int NUM_CHANNELS = 16,
  parameter int RING_DEPTH   = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // [3:0] channel, [51:4] timestamp_ms, [55:52] zero
  input  logic [0:0]  s_tuser,   // [0] is_relative
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // [3:0] out_channel, [13:4] latest_rate, [23:14] average_rate
);
  import erma_pkg::*;

  logic              push_valid;
  logic              push_ready;
  erma_item_t        push_item;
  logic              pop_valid;
  logic              pop;
  erma_item_t        pop_item;
  logic [CHAN_W-1:0] out_channel;
  logic [RATE_W-1:0] latest_rate;
  logic [RATE_W-1:0] average_rate;

  // The front filters requests and holds the one waiting for the queue.
  erma_front #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  erma_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_item   (pop_item)
  );

  // The back runs one request at a time and owns the result register.
  erma_back #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .RING_DEPTH   (RING_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_valid    (pop_valid),
    .pop          (pop),
    .pop_item     (pop_item),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_channel  (out_channel),
    .latest_rate  (latest_rate),
    .average_rate (average_rate)
  );

  assign m_tdata = {average_rate, latest_rate, out_channel};

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for the event rate moving average block.
`timescale 1ns / 1ps
module tb;
  import erma_pkg::*;

  localparam int NUM_CHANNELS = 16;
  localparam int RING_DEPTH = 64;
  localparam int RANDOM_REQUESTS = 1150;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES = 100;
  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    logic [CHAN_W-1:0] channel;
    logic [RATE_W-1:0] latest;
    logic [RATE_W-1:0] average;
  } rate_result_t;

  // Keeps its own copy of every channel's history and the rates that are still owed.
  class rate_meter_tracker;
    logic [TS_W-1:0]   last_time [NUM_CHANNELS];
    logic [RATE_W-1:0] rate_hist [NUM_CHANNELS*RING_DEPTH];
    logic [15:0]       hist_sum  [NUM_CHANNELS];
    logic [7:0]        head_slot [NUM_CHANNELS];
    logic [7:0]        fill      [NUM_CHANNELS];
    rate_result_t      pending_rates [$];
    int                mismatches;

    function new();
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        last_time[c] = '0;
        hist_sum[c] = '0;
        head_slot[c] = '0;
        fill[c] = '0;
      end
      for (int i = 0; i < NUM_CHANNELS * RING_DEPTH; i++) rate_hist[i] = '0;
      mismatches = 0;
    endfunction

    function void note_event(input logic [CHAN_W-1:0] ch, input logic rel,
                             input logic [TS_W-1:0] ts);
      logic [TS_W-1:0] gap;
      logic [TS_W-1:0] quotient;
      int              slot;
      rate_result_t    res;
      if (!rel) return;
      // Equal or earlier timestamps only move the reference time.
      if (ts <= last_time[ch]) begin
        last_time[ch] = ts;
        return;
      end
      gap = ts - last_time[ch];
      last_time[ch] = ts;
      if (gap > TS_W'(MS_PER_SEC)) return;
      quotient = TS_W'(MS_PER_SEC) / gap;
      slot = (int'(head_slot[ch]) + 1) % RING_DEPTH;
      head_slot[ch] = 8'(slot);
      hist_sum[ch] = hist_sum[ch] - 16'(rate_hist[ch*RING_DEPTH + slot])
                     + 16'(quotient[RATE_W-1:0]);
      rate_hist[ch*RING_DEPTH + slot] = quotient[RATE_W-1:0];
      if (fill[ch] < 8'(RING_DEPTH)) fill[ch] = fill[ch] + 8'd1;
      res.channel = ch;
      res.latest = quotient[RATE_W-1:0];
      res.average = RATE_W'(hist_sum[ch] / 16'(fill[ch]));
      pending_rates.push_back(res);
    endfunction

    function void check_result(input logic [CHAN_W-1:0] ch, input logic [RATE_W-1:0] latest,
                               input logic [RATE_W-1:0] average);
      rate_result_t want;
      if (pending_rates.size() == 0) begin
        $error("result on channel %0d arrived with none expected", ch);
        mismatches++;
        return;
      end
      want = pending_rates.pop_front();
      if (want.channel !== ch) begin
        $error("out_channel expected %0d actual %0d", want.channel, ch);
        mismatches++;
      end
      if (want.latest !== latest) begin
        $error("latest_rate expected %0d actual %0d", want.latest, latest);
        mismatches++;
      end
      if (want.average !== average) begin
        $error("average_rate expected %0d actual %0d", want.average, average);
        mismatches++;
      end
    endfunction

    function int pending();
      return pending_rates.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [55:0] s_tdata;   // [3:0] channel, [51:4] timestamp_ms, [55:52] zero
  logic [0:0]  s_tuser;   // [0] is_relative
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;   // [3:0] out_channel, [13:4] latest_rate, [23:14] average_rate

  rate_meter_tracker tracker;
  logic [TS_W-1:0]   stim_time [NUM_CHANNELS];
  int                send_idle_pct;
  int                recv_stall_pct;
  logic              hold_off_req;
  int                idle_cycles;

  event_rate_moving_average #(
    .NUM_CHANNELS(NUM_CHANNELS),
    .RING_DEPTH  (RING_DEPTH)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Accepted requests feed the tracker; accepted results are checked against it.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) tracker.note_event(s_tdata[3:0], s_tuser[0], s_tdata[51:4]);
      if (m_tvalid && m_tready) tracker.check_result(m_tdata[3:0], m_tdata[13:4], m_tdata[23:14]);
    end
  end

  // Result side: random stalls, plus one long hold-off on request from the main flow.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Ends the run when neither side has moved for too long.
  initial begin
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles = idle_cycles + 1;
    end
    $display("Mismatches found");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic offer_event(input logic [CHAN_W-1:0] ch, input logic rel,
                             input logic [TS_W-1:0] ts);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {4'b0000, ts, ch};
    s_tuser <= rel;
    if (rel) stim_time[ch] = ts;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic run_directed();
    offer_event(4'd0, 1'b1, 48'd1);        // first event, measured from zero, top rate
    offer_event(4'd0, 1'b1, 48'd1);        // zero interval
    offer_event(4'd0, 1'b0, 48'd500);      // not relative
    offer_event(4'd0, 1'b1, 48'd1001);     // exactly one second, lowest rate
    offer_event(4'd0, 1'b1, 48'd2002);     // just over one second
    offer_event(4'd0, 1'b1, 48'd2000);     // time going backwards
    offer_event(4'd0, 1'b1, 48'd2003);
    offer_event(4'd0, 1'b1, 48'd2504);
    offer_event(4'd15, 1'b1, 48'hFFFF_FFFF_FFFF);
    offer_event(4'd15, 1'b1, 48'hFFFF_FFFF_FFFF);
    offer_event(4'd15, 1'b0, 48'hFFFF_FFFF_FFFF);
    offer_event(4'd15, 1'b1, 48'd0);
    offer_event(4'd15, 1'b1, 48'd7);
    offer_event(4'd5, 1'b1, 48'hAAAA_AAAA_AAAA);
    offer_event(4'd5, 1'b1, 48'hAAAA_AAAA_AAAC);
    offer_event(4'd10, 1'b1, 48'h5555_5555_5555);
    offer_event(4'd10, 1'b1, 48'h5555_5555_5555 + 48'd999);
    offer_event(4'd3, 1'b1, 48'd1000);
    offer_event(4'd3, 1'b1, 48'd1500);
  endtask

  // Mostly steady event trains on a few busy channels, with the odd broken interval.
  task automatic run_random(input int count);
    int              sent;
    int              pick;
    logic [CHAN_W-1:0] ch;
    logic            rel;
    logic [TS_W-1:0] ts;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 1) == 0) ch = CHAN_W'($urandom_range(0, 1));
      else ch = CHAN_W'($urandom_range(0, NUM_CHANNELS - 1));
      pick = $urandom_range(0, 99);
      rel = 1'b1;
      if (pick < 40) ts = stim_time[ch] + TS_W'($urandom_range(1, 12));
      else if (pick < 75) ts = stim_time[ch] + TS_W'($urandom_range(1, MS_PER_SEC));
      else if (pick < 80) ts = stim_time[ch];
      else if (pick < 85) ts = stim_time[ch] + TS_W'($urandom_range(MS_PER_SEC + 1, 200000));
      else if (pick < 89) ts = stim_time[ch] - TS_W'($urandom_range(1, MS_PER_SEC));
      else if (pick < 92) ts = TS_W'({$urandom, $urandom});
      else begin
        rel = 1'b0;
        ts = TS_W'({$urandom, $urandom});
      end
      offer_event(ch, rel, ts);
      sent++;
    end
  endtask

  task automatic wait_drained();
    while (tracker.pending() != 0) @(negedge clk);
  endtask

  initial begin
    tracker = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_req = 1'b0;
    for (int c = 0; c < NUM_CHANNELS; c++) stim_time[c] = '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    run_directed();

    // The receiver holds off while requests keep coming, so the block backs up.
    hold_off_req = 1'b1;
    run_random(RANDOM_REQUESTS / 4);

    send_idle_pct = 66;
    run_random(RANDOM_REQUESTS / 4);
    wait_drained();

    send_idle_pct = 0;
    recv_stall_pct = 66;
    run_random(RANDOM_REQUESTS / 4);

    send_idle_pct = 16;
    recv_stall_pct = 16;
    run_random(RANDOM_REQUESTS / 4);

    s_tvalid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/erma_pkg.sv
rtl/core/erma_front.sv
rtl/core/erma_queue.sv
rtl/core/erma_div.sv
rtl/core/erma_back.sv
rtl/core/event_rate_moving_average.sv
sim/tb.sv
